### rtl/core/assert_macros.svh
// Assertion macros shared by the root finder core.
// Depends on nothing; files that assert take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property once reset is released.
`define PBRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define PBRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/core/pbrf_pkg.sv
// Shared types, constants and codes of the polynomial bisection root finder.
// Depends on nothing; every other file of the core but assert_macros.svh uses it.
package pbrf_pkg;

    localparam int DEF_MAX_TERMS = 64;
    localparam int DEF_MAX_ITER  = 48;

    localparam int IDX_W    = 6;
    localparam int COEF_W   = 16;
    localparam int Q_W      = 32;
    localparam int TOL_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = 64;
    localparam int STATUS_W = 2;
    localparam int ITER_W   = 6;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_TOL_MET    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXACT      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SIGN    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ITER_LIMIT = 2'd3;

    // -1.0 in Q16.16
    localparam logic [Q_W-1:0] ROOT_REJECT = 32'hFFFF_0000;

    localparam logic [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0_0000_0000_0001,
        ST_EV_INIT = 13'b0_0000_0000_0010,
        ST_EV_MAG  = 13'b0_0000_0000_0100,
        ST_EV_MLO  = 13'b0_0000_0000_1000,
        ST_EV_MHI  = 13'b0_0000_0001_0000,
        ST_EV_SUM  = 13'b0_0000_0010_0000,
        ST_EV_SAT  = 13'b0_0000_0100_0000,
        ST_EV_ADD  = 13'b0_0000_1000_0000,
        ST_SIGN    = 13'b0_0001_0000_0000,
        ST_CHECK   = 13'b0_0010_0000_0000,
        ST_MID     = 13'b0_0100_0000_0000,
        ST_UPD     = 13'b0_1000_0000_0000,
        ST_DONE    = 13'b1_0000_0000_0000
    } state_t;

    // point being evaluated
    typedef enum logic [1:0] {
        TGT_A = 2'd0,
        TGT_B = 2'd1,
        TGT_C = 2'd2
    } tgt_t;

    typedef enum logic [2:0] {
        RES_REJECT    = 3'd0,
        RES_ROOT_A    = 3'd1,
        RES_ROOT_B    = 3'd2,
        RES_MID_EXACT = 3'd3,
        RES_MID_END   = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } sgn_t;

    typedef struct packed {
        logic      load_we;
        logic      solve_capture;
        logic      ev_start;
        logic      ev_mag;
        logic      ev_mlo;
        logic      ev_mhi;
        logic      ev_sum;
        logic      ev_sat;
        logic      ev_add;
        logic      store_f;
        logic      mid_step;
        logic      upd_a;
        logic      upd_b;
        logic      res_write;
        tgt_t      x_sel;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic term_last;
        logic reject;
        logic fa_zero;
        logic fb_zero;
        logic fc_zero;
        logic fc_opp;
        logic above;
        logic iter_done;
        logic res_room;
    } dp_stat_t;

endpackage

### rtl/core/pbrf_ifs.sv
// Handshake channels of the root finder: input items, results, configuration.
// Depends on pbrf_pkg for the payload widths.
interface pbrf_item_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic        [pbrf_pkg::IDX_W-1:0]   coef_index;
    logic signed [pbrf_pkg::COEF_W-1:0]  coef_value;
    logic signed [pbrf_pkg::Q_W-1:0]     left_end;
    logic signed [pbrf_pkg::Q_W-1:0]     right_end;
    logic        [pbrf_pkg::TOL_W-1:0]   tolerance;

    modport source (
        output valid, cmd, coef_index, coef_value, left_end, right_end, tolerance,
        input  ready
    );
    modport sink (
        input  valid, cmd, coef_index, coef_value, left_end, right_end, tolerance,
        output ready
    );
endinterface

interface pbrf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pbrf_pkg::Q_W-1:0]      root;
    logic        [pbrf_pkg::STATUS_W-1:0] status;
    logic        [pbrf_pkg::ITER_W-1:0]   iterations;

    modport source (
        output valid, root, status, iterations,
        input  ready
    );
    modport sink (
        input  valid, root, status, iterations,
        output ready
    );
endinterface

interface pbrf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pbrf_pkg::IDX_W-1:0]    data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

### rtl/core/pbrf_ctrl.sv
// Sequencer of the root finder: Horner term phases, bracket checks, bisection loop.
// Depends on pbrf_pkg; drives pbrf_datapath through ctrl_cmd_t and reads dp_stat_t.
module pbrf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_cmd,
    output logic                item_ready,
    input  pbrf_pkg::dp_stat_t  stat,
    output pbrf_pkg::ctrl_cmd_t cmd
);

    pbrf_pkg::state_t    state_reg, state_next;
    pbrf_pkg::tgt_t      tgt_reg, tgt_next;
    pbrf_pkg::res_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbrf_pkg::ST_IDLE;
            tgt_reg   <= pbrf_pkg::TGT_A;
            kind_reg  <= pbrf_pkg::RES_REJECT;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tgt_next     = tgt_reg;
        kind_next    = kind_reg;
        item_ready   = 1'b0;
        cmd          = '0;
        cmd.x_sel    = tgt_reg;
        cmd.res_kind = kind_reg;
        unique case (state_reg)
            pbrf_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_cmd == pbrf_pkg::CMD_SOLVE)
                    begin
                        cmd.solve_capture = 1'b1;
                        tgt_next          = pbrf_pkg::TGT_A;
                        state_next        = pbrf_pkg::ST_EV_INIT;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            pbrf_pkg::ST_EV_INIT:
            begin
                cmd.ev_start = 1'b1;
                state_next   = pbrf_pkg::ST_EV_MAG;
            end
            pbrf_pkg::ST_EV_MAG:
            begin
                cmd.ev_mag = 1'b1;
                state_next = pbrf_pkg::ST_EV_MLO;
            end
            pbrf_pkg::ST_EV_MLO:
            begin
                cmd.ev_mlo = 1'b1;
                state_next = pbrf_pkg::ST_EV_MHI;
            end
            pbrf_pkg::ST_EV_MHI:
            begin
                cmd.ev_mhi = 1'b1;
                state_next = pbrf_pkg::ST_EV_SUM;
            end
            pbrf_pkg::ST_EV_SUM:
            begin
                cmd.ev_sum = 1'b1;
                state_next = pbrf_pkg::ST_EV_SAT;
            end
            pbrf_pkg::ST_EV_SAT:
            begin
                cmd.ev_sat = 1'b1;
                state_next = pbrf_pkg::ST_EV_ADD;
            end
            pbrf_pkg::ST_EV_ADD:
            begin
                cmd.ev_add = 1'b1;
                state_next = stat.term_last ? pbrf_pkg::ST_SIGN : pbrf_pkg::ST_EV_MAG;
            end
            pbrf_pkg::ST_SIGN:
            begin
                cmd.store_f = 1'b1;
                unique case (tgt_reg)
                    pbrf_pkg::TGT_A:
                    begin
                        tgt_next   = pbrf_pkg::TGT_B;
                        state_next = pbrf_pkg::ST_EV_INIT;
                    end
                    pbrf_pkg::TGT_B: state_next = pbrf_pkg::ST_CHECK;
                    pbrf_pkg::TGT_C: state_next = pbrf_pkg::ST_UPD;
                    default:         state_next = pbrf_pkg::ST_IDLE;
                endcase
            end
            pbrf_pkg::ST_CHECK:
            begin
                priority if (stat.reject)
                begin
                    kind_next  = pbrf_pkg::RES_REJECT;
                    state_next = pbrf_pkg::ST_DONE;
                end
                else if (stat.fa_zero)
                begin
                    kind_next  = pbrf_pkg::RES_ROOT_A;
                    state_next = pbrf_pkg::ST_DONE;
                end
                else if (stat.fb_zero)
                begin
                    kind_next  = pbrf_pkg::RES_ROOT_B;
                    state_next = pbrf_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pbrf_pkg::ST_MID;
                end
            end
            pbrf_pkg::ST_MID:
            begin
                cmd.mid_step = 1'b1;
                tgt_next     = pbrf_pkg::TGT_C;
                state_next   = pbrf_pkg::ST_EV_INIT;
            end
            pbrf_pkg::ST_UPD:
            begin
                if (stat.fc_zero)
                begin
                    kind_next  = pbrf_pkg::RES_MID_EXACT;
                    state_next = pbrf_pkg::ST_DONE;
                end
                else
                begin
                    // replace the end whose sign matches the midpoint
                    if (stat.fc_opp)
                    begin
                        cmd.upd_b = 1'b1;
                    end
                    else
                    begin
                        cmd.upd_a = 1'b1;
                    end
                    if (stat.above && !stat.iter_done)
                    begin
                        state_next = pbrf_pkg::ST_MID;
                    end
                    else
                    begin
                        kind_next  = pbrf_pkg::RES_MID_END;
                        state_next = pbrf_pkg::ST_DONE;
                    end
                end
            end
            pbrf_pkg::ST_DONE:
            begin
                // hold until the output register can take the result
                if (stat.res_room)
                begin
                    cmd.res_write = 1'b1;
                    state_next    = pbrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbrf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/pbrf_datapath.sv
// Datapath of the root finder: coefficient memory, Horner unit with a shared
// 32x32 multiplier, bracket and tolerance registers, result register.
// Depends on pbrf_pkg and assert_macros.svh; sequenced by pbrf_ctrl.
`include "assert_macros.svh"

module pbrf_datapath #(
    parameter int MAX_TERMS = pbrf_pkg::DEF_MAX_TERMS,
    parameter int MAX_ITER  = pbrf_pkg::DEF_MAX_ITER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pbrf_pkg::ctrl_cmd_t                 cmd,
    output pbrf_pkg::dp_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic        [pbrf_pkg::IDX_W-1:0]   cfg_data,
    input  logic        [pbrf_pkg::IDX_W-1:0]   coef_index,
    input  logic signed [pbrf_pkg::COEF_W-1:0]  coef_value,
    input  logic signed [pbrf_pkg::Q_W-1:0]     left_end,
    input  logic signed [pbrf_pkg::Q_W-1:0]     right_end,
    input  logic        [pbrf_pkg::TOL_W-1:0]   tolerance,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [pbrf_pkg::Q_W-1:0]     root,
    output logic        [pbrf_pkg::STATUS_W-1:0] status,
    output logic        [pbrf_pkg::ITER_W-1:0]  iterations
);

    localparam int AW   = $clog2(MAX_TERMS);
    localparam int IT_W = $clog2(MAX_ITER + 1);
    localparam int QW   = pbrf_pkg::Q_W;
    localparam int AccW = pbrf_pkg::ACC_W;
    localparam int CW   = pbrf_pkg::COEF_W;
    localparam int FW   = pbrf_pkg::FRAC_W;

    // configuration and coefficient store
    logic [pbrf_pkg::IDX_W-1:0] poly_degree_reg;
    logic [MAX_TERMS-1:0]       coef_valid_reg;
    logic [CW-1:0]              coef_mem [MAX_TERMS];
    logic [CW-1:0]              rd_data_reg;
    logic                       rd_ok_reg;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic                       rd_in_range;

    // bracket state
    logic [QW-1:0]     a_reg, b_reg, c_reg;
    pbrf_pkg::sgn_t    fa_reg, fb_reg, fc_reg;
    logic [QW-1:0]     width_reg;
    logic [QW:0]       tol_sh_reg, tol_sh_next;
    logic              above_reg;
    logic [IT_W-1:0]   it_reg;
    logic              iter_done;
    logic [QW:0]       mid_sum;
    logic [QW-1:0]     width_next;

    // Horner unit
    logic [pbrf_pkg::IDX_W-1:0] idx_reg;
    logic [AccW-1:0]   acc_reg, acc_next;
    logic [QW-1:0]     x_mag_reg;
    logic              x_neg_reg;
    logic [QW-1:0]     x_pick;
    logic [AccW-1:0]   ma_reg;
    logic              pneg_reg;
    logic [QW-1:0]     mul_a;
    logic [2*QW-1:0]   mul_p;
    logic [2*QW-1:0]   p0_reg, p1_reg;
    logic [3*QW-1:0]   full_sum;
    logic              ovf_reg;
    logic [AccW-1:0]   q_reg;
    logic [AccW-1:0]   prod_reg, prod_next;
    logic [CW-1:0]     coef_term;
    logic [AccW-1:0]   term;
    logic [AccW:0]     add_sum;

    // result register
    logic                             out_valid_reg;
    logic [QW-1:0]                    root_reg;
    logic [pbrf_pkg::STATUS_W-1:0]    status_reg;
    logic [pbrf_pkg::ITER_W-1:0]      iters_reg;

    // ---------------------------------------------------------------- store
    assign wr_en       = cmd.load_we && (int'(coef_index) < MAX_TERMS);
    assign wr_addr     = AW'(coef_index);
    assign rd_addr     = AW'(idx_reg);
    assign rd_in_range = int'(idx_reg) < MAX_TERMS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= '0;
            coef_valid_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                poly_degree_reg <= cfg_data;
            end
            if (wr_en)
            begin
                coef_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coef_mem[wr_addr] <= coef_value;
        end
        if (cmd.ev_mag)
        begin
            rd_data_reg <= coef_mem[rd_addr];
            rd_ok_reg   <= rd_in_range && coef_valid_reg[rd_addr];
        end
    end

    // -------------------------------------------------------------- bracket
    assign width_next = (left_end >= right_end) ? QW'(left_end - right_end)
                                                : QW'(right_end - left_end);
    assign mid_sum    = {a_reg[QW-1], a_reg} + {b_reg[QW-1], b_reg};
    // stop doubling once past any possible width
    assign tol_sh_next = tol_sh_reg[QW] ? tol_sh_reg : {tol_sh_reg[QW-1:0], 1'b0};
    assign iter_done   = int'(it_reg) >= MAX_ITER;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg <= '0;
        end
        else if (cmd.solve_capture)
        begin
            it_reg <= '0;
        end
        else if (cmd.mid_step)
        begin
            it_reg <= it_reg + IT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.solve_capture)
        begin
            a_reg      <= left_end;
            b_reg      <= right_end;
            width_reg  <= width_next;
            tol_sh_reg <= {2'b00, tolerance};
        end
        if (cmd.mid_step)
        begin
            c_reg      <= mid_sum[QW:1];
            tol_sh_reg <= tol_sh_next;
            above_reg  <= {1'b0, width_reg} > tol_sh_next;
        end
        if (cmd.store_f)
        begin
            unique case (cmd.x_sel)
                pbrf_pkg::TGT_A: fa_reg <= '{neg: acc_reg[AccW-1], zero: acc_reg == '0};
                pbrf_pkg::TGT_B: fb_reg <= '{neg: acc_reg[AccW-1], zero: acc_reg == '0};
                pbrf_pkg::TGT_C: fc_reg <= '{neg: acc_reg[AccW-1], zero: acc_reg == '0};
                default:         fc_reg <= fc_reg;
            endcase
        end
        if (cmd.upd_a)
        begin
            a_reg  <= c_reg;
            fa_reg <= fc_reg;
        end
        if (cmd.upd_b)
        begin
            b_reg  <= c_reg;
            fb_reg <= fc_reg;
        end
    end

    // --------------------------------------------------------------- Horner
    always_comb
    begin
        unique case (cmd.x_sel)
            pbrf_pkg::TGT_A: x_pick = a_reg;
            pbrf_pkg::TGT_B: x_pick = b_reg;
            pbrf_pkg::TGT_C: x_pick = c_reg;
            default:         x_pick = c_reg;
        endcase
    end

    assign mul_a    = cmd.ev_mhi ? ma_reg[AccW-1:QW] : ma_reg[QW-1:0];
    assign mul_p    = mul_a * x_mag_reg;
    assign full_sum = {{QW{1'b0}}, p0_reg} + {p1_reg, {QW{1'b0}}};

    always_comb
    begin
        priority if (ovf_reg)
        begin
            prod_next = pneg_reg ? pbrf_pkg::ACC_MIN : pbrf_pkg::ACC_MAX;
        end
        else if (pneg_reg)
        begin
            prod_next = q_reg[AccW-1] ? pbrf_pkg::ACC_MIN : (AccW'(0) - q_reg);
        end
        else
        begin
            prod_next = q_reg[AccW-1] ? pbrf_pkg::ACC_MAX : q_reg;
        end
    end

    assign coef_term = rd_ok_reg ? rd_data_reg : '0;
    assign term      = {{(AccW-CW-FW){coef_term[CW-1]}}, coef_term, {FW{1'b0}}};
    assign add_sum   = {prod_reg[AccW-1], prod_reg} + {term[AccW-1], term};

    always_comb
    begin
        if (add_sum[AccW] != add_sum[AccW-1])
        begin
            acc_next = add_sum[AccW] ? pbrf_pkg::ACC_MIN : pbrf_pkg::ACC_MAX;
        end
        else
        begin
            acc_next = add_sum[AccW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ev_start)
        begin
            acc_reg   <= '0;
            idx_reg   <= poly_degree_reg;
            x_neg_reg <= x_pick[QW-1];
            x_mag_reg <= x_pick[QW-1] ? (QW'(0) - x_pick) : x_pick;
        end
        if (cmd.ev_mag)
        begin
            ma_reg   <= acc_reg[AccW-1] ? (AccW'(0) - acc_reg) : acc_reg;
            pneg_reg <= acc_reg[AccW-1] ^ x_neg_reg;
        end
        if (cmd.ev_mlo)
        begin
            p0_reg <= mul_p;
        end
        if (cmd.ev_mhi)
        begin
            p1_reg <= mul_p;
        end
        if (cmd.ev_sum)
        begin
            // drop the 16 fraction bits; anything above bit 79 overflows
            ovf_reg <= |full_sum[3*QW-1:AccW+FW];
            q_reg   <= full_sum[AccW+FW-1:FW];
        end
        if (cmd.ev_sat)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.ev_add)
        begin
            acc_reg <= acc_next;
            idx_reg <= idx_reg - pbrf_pkg::IDX_W'(1);
        end
    end

    // --------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_write)
        begin
            iters_reg <= pbrf_pkg::ITER_W'(it_reg);
            unique case (cmd.res_kind)
                pbrf_pkg::RES_REJECT:
                begin
                    root_reg   <= pbrf_pkg::ROOT_REJECT;
                    status_reg <= pbrf_pkg::STAT_NO_SIGN;
                end
                pbrf_pkg::RES_ROOT_A:
                begin
                    root_reg   <= a_reg;
                    status_reg <= pbrf_pkg::STAT_EXACT;
                end
                pbrf_pkg::RES_ROOT_B:
                begin
                    root_reg   <= b_reg;
                    status_reg <= pbrf_pkg::STAT_EXACT;
                end
                pbrf_pkg::RES_MID_EXACT:
                begin
                    root_reg   <= c_reg;
                    status_reg <= pbrf_pkg::STAT_EXACT;
                end
                pbrf_pkg::RES_MID_END:
                begin
                    root_reg   <= c_reg;
                    status_reg <= above_reg ? pbrf_pkg::STAT_ITER_LIMIT
                                            : pbrf_pkg::STAT_TOL_MET;
                end
                default:
                begin
                    root_reg   <= pbrf_pkg::ROOT_REJECT;
                    status_reg <= pbrf_pkg::STAT_NO_SIGN;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign root       = root_reg;
    assign status     = status_reg;
    assign iterations = iters_reg;

    // --------------------------------------------------------------- status
    assign stat.term_last = idx_reg == '0;
    assign stat.reject    = !fa_reg.zero && !fb_reg.zero && (fa_reg.neg == fb_reg.neg);
    assign stat.fa_zero   = fa_reg.zero;
    assign stat.fb_zero   = fb_reg.zero;
    assign stat.fc_zero   = fc_reg.zero;
    assign stat.fc_opp    = fc_reg.neg != fa_reg.neg;
    assign stat.above     = above_reg;
    assign stat.iter_done = iter_done;
    assign stat.res_room  = !out_valid_reg || out_ready;

    `PBRF_ASSERT(a_res_no_overwrite, clk, rst_n, cmd.res_write && out_valid_reg |-> out_ready, "result overwritten before delivery")
    `PBRF_ASSERT(a_step_within_limit, clk, rst_n, cmd.mid_step |-> !iter_done, "halving past the iteration limit")
    `PBRF_ASSERT(a_bracket_live, clk, rst_n, (cmd.upd_a || cmd.upd_b) |-> !fa_reg.zero && !fc_reg.zero, "bracket update with a zero end value")
    `PBRF_ASSERT_ALWAYS(a_valid_from_write, clk, $rose(out_valid_reg) |-> $past(cmd.res_write), "result valid without a result write")

endmodule

### rtl/core/polynomial_bisection_root_finder_top.sv
// A load is accepted and gives no result. Each evaluation in a solve runs a Horner step per
// term (D+1 terms, D = poly_degree; one 32x32 multiplier used twice per term); a solve
// evaluates both ends and then the midpoint of each of its k halvings (k <= MAX_ITER).
// One item is worked at a time; the next is accepted once the result is registered.
// Reset clears the degree to 0 and every coefficient valid bit at once: no clearing pass.
// Top level: joins pbrf_ctrl and pbrf_datapath to the item, result and config channels.
module polynomial_bisection_root_finder_top #(
    parameter int MAX_TERMS = pbrf_pkg::DEF_MAX_TERMS,
    parameter int MAX_ITER  = pbrf_pkg::DEF_MAX_ITER
) (
    input  logic         clk,
    input  logic         rst_n,
    pbrf_item_if.sink    item,
    pbrf_result_if.source result,
    pbrf_cfg_if.sink     cfg
);

    pbrf_pkg::ctrl_cmd_t cmd;
    pbrf_pkg::dp_stat_t  stat;

    // the degree register takes a write in any cycle
    assign cfg.ready = 1'b1;

    pbrf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pbrf_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_ITER  (MAX_ITER)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .coef_index (item.coef_index),
        .coef_value (item.coef_value),
        .left_end   (item.left_end),
        .right_end  (item.right_end),
        .tolerance  (item.tolerance),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .root       (result.root),
        .status     (result.status),
        .iterations (result.iterations)
    );

endmodule
